>>> rtl/full_text_justifier_defines.svh
// Assertion macros shared by the checker.
`ifndef FULL_TEXT_JUSTIFIER_DEFINES_SVH
`define FULL_TEXT_JUSTIFIER_DEFINES_SVH

// same-cycle implication
`define FTJ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ftj check failed");

// next-cycle implication
`define FTJ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ftj check failed");

`endif

>>> rtl/ftj_pkg.sv
package ftj_pkg;

  localparam int CHAR_W         = 8;
  localparam int CFG_W          = 6;
  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_WORDS_DEF  = 16;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'd32;
  localparam logic [CFG_W-1:0]  LINE_WIDTH_RST = 6'd32;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_space;
    logic              eot;
  } tok_t;

endpackage

>>> rtl/full_text_justifier.sv
// Greedy full-text justifier. Text bytes enter one per beat (32 is a space,
// runs of spaces are one separator); justified lines leave one character per
// beat, end_of_line marking the last one and word_cut marking every
// character of a line that holds a word clipped to the width. The user must
// see that line_width is written only while the block is idle; the block does
// not enforce this. The front stage registers a byte and queues it; the back
// engine reads the letters of a word, then commits the word into the held
// line with a check step and a copy of each letter, and per line runs a setup
// step, a restoring divide (skipped for a lone word) and then emits each
// character, with steps for the gaps and the line end. The back engine sets
// the sustained rate; the queue hides the per-line setup for short bursts.
// Emission waits while out_stall_i is high and an output beat is held.
module full_text_justifier #(
  parameter int MAX_WIDTH  = ftj_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WORDS  = ftj_pkg::MAX_WORDS_DEF,
  parameter int FIFO_DEPTH = ftj_pkg::FIFO_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ftj_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ftj_pkg::CHAR_W-1:0] char_code_i,
  input  logic                       end_of_text_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ftj_pkg::CHAR_W-1:0] out_char_o,
  output logic                       end_of_line_o,
  output logic                       word_cut_o
);

  logic [ftj_pkg::CFG_W-1:0] line_width_q;
  logic                      push, full, pop, empty;
  ftj_pkg::tok_t             tok_in, tok_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= ftj_pkg::LINE_WIDTH_RST;
    end else if (cfg_we_i) begin
      line_width_q <= cfg_wdata_i;
    end
  end

  ftj_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .tok_o         (tok_in),
    .full_i        (full)
  );

  ftj_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (tok_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (tok_out),
    .empty_o (empty)
  );

  ftj_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WORDS (MAX_WORDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_width_i  (line_width_q),
    .tok_i         (tok_out),
    .tok_empty_i   (empty),
    .tok_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .end_of_line_o (end_of_line_o),
    .word_cut_o    (word_cut_o)
  );

endmodule

>>> rtl/ftj_front.sv
module ftj_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ftj_pkg::CHAR_W-1:0] char_code_i,
  input  logic                      end_of_text_i,
  output logic                      push_o,
  output ftj_pkg::tok_t             tok_o,
  input  logic                      full_i
);

  logic          tok_valid_q;
  ftj_pkg::tok_t tok_q;
  logic          accept;

  assign in_stall_o = tok_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = tok_valid_q && !full_i;
  assign tok_o      = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        tok_valid_q <= 1'b1;
      end else if (push_o) begin
        tok_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q.ch       <= char_code_i;
      tok_q.is_space <= (char_code_i == ftj_pkg::SPACE_CODE);
      tok_q.eot      <= end_of_text_i;
    end
  end

endmodule

>>> rtl/ftj_fifo.sv
module ftj_fifo #(
  parameter int DEPTH = ftj_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ftj_pkg::tok_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output ftj_pkg::tok_t data_o,
  output logic          empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ftj_pkg::tok_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/ftj_back.sv
module ftj_back #(
  parameter int MAX_WIDTH = ftj_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WORDS = ftj_pkg::MAX_WORDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ftj_pkg::CFG_W-1:0]  line_width_i,
  input  ftj_pkg::tok_t              tok_i,
  input  logic                       tok_empty_i,
  output logic                       tok_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ftj_pkg::CHAR_W-1:0] out_char_o,
  output logic                       end_of_line_o,
  output logic                       word_cut_o
);

  localparam int LW  = $clog2(MAX_WIDTH + 1);
  localparam int LIW = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WORDS + 1);
  localparam int WIW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int SW  = $clog2(2 * MAX_WIDTH + MAX_WORDS + 1);
  localparam int DCW = $clog2(SW);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_APPEND, ST_SETUP, ST_DIV, ST_WALK
  } state_e;

  typedef enum logic [1:0] {PH_LET, PH_SPC, PH_PAD} phase_e;

  state_e state_q;
  phase_e phase_q;

  logic [ftj_pkg::CHAR_W-1:0] line_q [MAX_WIDTH];
  logic [ftj_pkg::CHAR_W-1:0] pend_q [MAX_WIDTH];
  logic [LW-1:0]              wl_q   [MAX_WORDS];

  logic [LW-1:0]  pl_q, lt_q, ci_q, j_q, pos_q, cnt_q, len_q;
  logic [WW-1:0]  wc_q;
  logic [WIW-1:0] wi_q;
  logic           pcut_q, cut_q, flush_q, ret_q;
  logic [SW-1:0]  gaps_q, q_q, r_q, sp_q;
  logic [DCW-1:0] dc_q;

  logic                       out_valid_q, out_eol_q, out_cut_q;
  logic [ftj_pkg::CHAR_W-1:0] out_char_q;

  logic [LW-1:0]  wn, lt_new;
  logic           out_free, no_fit, last_word, extra_hit, ge;
  logic           emit_now;
  logic [ftj_pkg::CHAR_W-1:0] emit_ch;
  logic [SW-1:0]  fit_sum, gaps, s_g, wp, total, app_dst, lt_sum, r_n;
  logic [SW:0]    r_t;

  always_comb begin
    if (line_width_i == '0) begin
      wn = LW'(1);
    end else if (line_width_i > ftj_pkg::CFG_W'(MAX_WIDTH)) begin
      wn = LW'(MAX_WIDTH);
    end else begin
      wn = LW'(line_width_i);
    end
  end

  assign out_free  = !out_valid_q || !out_stall_i;
  assign tok_pop_o = (state_q == ST_IDLE) && !tok_empty_i;

  assign fit_sum = SW'(lt_q) + SW'(pl_q) + SW'(wc_q);
  assign no_fit  = (wc_q != '0) && ((wc_q >= WW'(MAX_WORDS)) || (fit_sum > SW'(wn)));

  // line geometry; a line that outgrew the width gets single gaps
  assign gaps  = SW'(wc_q) - SW'(1);
  assign s_g   = SW'(lt_q) + gaps;
  assign wp    = (SW'(wn) > s_g) ? SW'(wn) : s_g;
  assign total = wp - SW'(lt_q);

  assign app_dst = SW'(lt_q) + SW'(ci_q);
  assign lt_sum  = SW'(lt_q) + SW'(pl_q);
  assign lt_new  = (lt_sum > SW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : lt_sum[LW-1:0];

  // restoring divide, one quotient bit per cycle
  assign r_t = {r_q, q_q[SW-1]};
  assign ge  = (r_t >= {1'b0, gaps_q});
  assign r_n = ge ? SW'(r_t - {1'b0, gaps_q}) : r_t[SW-1:0];

  assign last_word = (WW'(wi_q) + WW'(1) >= wc_q);
  assign extra_hit = (SW'(wi_q) < r_q);

  always_comb begin
    emit_now = 1'b0;
    emit_ch  = ftj_pkg::SPACE_CODE;
    case (phase_q)
      PH_LET: begin
        if (j_q < wl_q[wi_q] && pos_q < LW'(MAX_WIDTH) && cnt_q < len_q) begin
          emit_now = 1'b1;
          emit_ch  = line_q[pos_q[LIW-1:0]];
        end
      end
      PH_SPC:  emit_now = (sp_q != '0) && (cnt_q < len_q);
      PH_PAD:  emit_now = (cnt_q < len_q);
      default: emit_now = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_LET;
      pl_q        <= '0;
      pcut_q      <= 1'b0;
      wc_q        <= '0;
      lt_q        <= '0;
      cut_q       <= 1'b0;
      flush_q     <= 1'b0;
      ret_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!tok_empty_i) begin
            if (!tok_i.is_space) begin
              if (pl_q < wn) begin
                pl_q <= pl_q + LW'(1);
              end else begin
                pcut_q <= 1'b1;
              end
            end
            flush_q <= tok_i.eot;
            if (tok_i.is_space || tok_i.eot) begin
              state_q <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (pl_q == '0) begin
            ret_q   <= 1'b0;
            state_q <= flush_q ? ST_SETUP : ST_IDLE;
          end else if (no_fit) begin
            ret_q   <= 1'b1;
            state_q <= ST_SETUP;
          end else begin
            ci_q    <= '0;
            state_q <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          ci_q <= ci_q + LW'(1);
          if (ci_q + LW'(1) == pl_q) begin
            wc_q   <= wc_q + WW'(1);
            lt_q   <= lt_new;
            cut_q  <= cut_q | pcut_q;
            pl_q   <= '0;
            pcut_q <= 1'b0;
            ret_q  <= 1'b0;
            state_q <= flush_q ? ST_SETUP : ST_IDLE;
          end
        end
        ST_SETUP: begin
          if (wc_q == '0) begin
            ci_q    <= '0;
            state_q <= ret_q ? ST_APPEND : ST_IDLE;
          end else begin
            gaps_q  <= gaps;
            q_q     <= total;
            r_q     <= '0;
            dc_q    <= '0;
            len_q   <= (wp > SW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : wp[LW-1:0];
            wi_q    <= '0;
            j_q     <= '0;
            pos_q   <= '0;
            cnt_q   <= '0;
            phase_q <= PH_LET;
            state_q <= (wc_q == WW'(1)) ? ST_WALK : ST_DIV;
          end
        end
        ST_DIV: begin
          r_q  <= r_n;
          q_q  <= {q_q[SW-2:0], ge};
          dc_q <= dc_q + DCW'(1);
          if (dc_q == DCW'(SW - 1)) begin
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (out_free) begin
            if (emit_now) begin
              out_valid_q <= 1'b1;
              out_char_q  <= emit_ch;
              out_eol_q   <= (cnt_q + LW'(1) == len_q);
              out_cut_q   <= cut_q;
              cnt_q       <= cnt_q + LW'(1);
            end
            unique case (phase_q)
              PH_LET: begin
                if (j_q < wl_q[wi_q]) begin
                  if (pos_q < LW'(MAX_WIDTH)) begin
                    pos_q <= pos_q + LW'(1);
                  end
                  j_q <= j_q + LW'(1);
                end else if (!last_word) begin
                  sp_q    <= q_q + SW'(extra_hit);
                  phase_q <= PH_SPC;
                end else if (wc_q == WW'(1)) begin
                  phase_q <= PH_PAD;
                end else begin
                  wc_q    <= '0;
                  lt_q    <= '0;
                  cut_q   <= 1'b0;
                  ci_q    <= '0;
                  state_q <= ret_q ? ST_APPEND : ST_IDLE;
                end
              end
              PH_SPC: begin
                if (sp_q != '0) begin
                  sp_q <= sp_q - SW'(1);
                end else begin
                  wi_q    <= wi_q + WIW'(1);
                  j_q     <= '0;
                  phase_q <= PH_LET;
                end
              end
              PH_PAD: begin
                if (!emit_now) begin
                  wc_q    <= '0;
                  lt_q    <= '0;
                  cut_q   <= 1'b0;
                  ci_q    <= '0;
                  state_q <= ret_q ? ST_APPEND : ST_IDLE;
                end
              end
              default: phase_q <= PH_LET;
            endcase
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // letter stores
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && !tok_empty_i && !tok_i.is_space && pl_q < wn) begin
      pend_q[pl_q[LIW-1:0]] <= tok_i.ch;
    end
    if (state_q == ST_APPEND) begin
      if (app_dst < SW'(MAX_WIDTH)) begin
        line_q[app_dst[LIW-1:0]] <= pend_q[ci_q[LIW-1:0]];
      end
      if (ci_q + LW'(1) == pl_q) begin
        wl_q[wc_q[WIW-1:0]] <= pl_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign end_of_line_o = out_eol_q;
  assign word_cut_o    = out_cut_q;

endmodule

>>> rtl/ftj_checker.sv
`include "full_text_justifier_defines.svh"

module ftj_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_we_i,
  input logic [ftj_pkg::CFG_W-1:0]  cfg_wdata_i,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [ftj_pkg::CHAR_W-1:0] char_code_i,
  input logic                       end_of_text_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [ftj_pkg::CHAR_W-1:0] out_char_o,
  input logic                       end_of_line_o,
  input logic                       word_cut_o
);

  // a stalled output beat holds
  `FTJ_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_char_o) && $stable(end_of_line_o))

  // input stall only follows a taken or stalled beat
  `FTJ_ASSERT_IMP(a_in_stall_src, in_stall_o, $past(in_valid_i) || $past(in_stall_o))

  // cut flag is constant across back-to-back beats of one line
  `FTJ_ASSERT_IMP(a_cut_steady, (out_valid_o && !out_stall_i && !end_of_line_o) ##1 out_valid_o, word_cut_o == $past(word_cut_o))

endmodule

bind full_text_justifier ftj_checker u_ftj_checker (.*);

>>> dv/full_text_justifier_tb.sv
`timescale 1ns / 1ps

class justify_scoreboard;
  bit [7:0]  line_chars[32];
  bit [5:0]  word_len[16];
  int        n_words;
  int        n_letters;
  bit [7:0]  word_buf[32];
  int        word_size;
  bit        line_cut;
  bit        word_cut;
  bit [5:0]  width_reg;
  bit [9:0]  char_q[$];
  int        n_errors;

  function new();
    width_reg = ftj_pkg::LINE_WIDTH_RST;
  endfunction

  function int eff_width();
    if (width_reg < 1) return 1;
    if (width_reg > 32) return 32;
    return width_reg;
  endfunction

  function void flush_line();
    bit [7:0] buf_c[32];
    int len, pos, w, gaps, total, each, extra, sp;
    len = 0;
    pos = 0;
    w = eff_width();
    if (n_words == 0) return;
    gaps = n_words - 1;
    if (w < n_letters + gaps) w = n_letters + gaps;
    total = w - n_letters;
    each = 0;
    extra = 0;
    if (gaps > 0) begin
      each = total / gaps;
      extra = total % gaps;
    end
    for (int i = 0; i < n_words && i < 16; i++) begin
      for (int j = 0; j < word_len[i]; j++) begin
        if (len < 32 && pos < 32) begin
          buf_c[len] = line_chars[pos];
          len++;
        end
        pos++;
      end
      if (i + 1 < n_words) begin
        sp = each + ((i < extra) ? 1 : 0);
        for (int j = 0; j < sp && len < 32; j++) begin
          buf_c[len] = ftj_pkg::SPACE_CODE;
          len++;
        end
      end
    end
    if (n_words == 1)
      while (len < w && len < 32) begin
        buf_c[len] = ftj_pkg::SPACE_CODE;
        len++;
      end
    for (int i = 0; i < len; i++) char_q.push_back({buf_c[i], i + 1 == len, line_cut});
    n_words = 0;
    n_letters = 0;
    line_cut = 0;
  endfunction

  function void place_word();
    if (word_size == 0) return;
    if (n_words > 0 && (n_words >= 16 || n_letters + word_size + n_words > eff_width()))
      flush_line();
    for (int i = 0; i < word_size && i < 32; i++)
      if (n_letters + i < 32) line_chars[n_letters + i] = word_buf[i];
    if (n_words < 16) begin
      word_len[n_words] = 6'(word_size);
      n_words++;
    end
    n_letters += word_size;
    if (n_letters > 32) n_letters = 32;
    line_cut |= word_cut;
    word_size = 0;
    word_cut = 0;
  endfunction

  function void note_byte(bit [7:0] ch, bit eot);
    if (ch == ftj_pkg::SPACE_CODE) place_word();
    else if (word_size < eff_width()) begin
      word_buf[word_size] = ch;
      word_size++;
    end else word_cut = 1;
    if (eot) begin
      place_word();
      flush_line();
    end
  endfunction

  function void check_char(bit [7:0] ch, bit eol, bit cut);
    bit [9:0] exp_c;
    if (char_q.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("unexpected beat: char %0d eol %0b cut %0b", ch, eol, cut);
      return;
    end
    exp_c = char_q.pop_front();
    if (exp_c != {ch, eol, cut}) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch: exp char %0d eol %0b cut %0b, got char %0d eol %0b cut %0b",
                 exp_c[9:2], exp_c[1], exp_c[0], ch, eol, cut);
    end
  endfunction
endclass

module full_text_justifier_tb;
  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [5:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] char_code_i;
  logic       end_of_text_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic       end_of_line_o;
  logic       word_cut_o;

  justify_scoreboard sb;
  int  idle_pct;

  full_text_justifier u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .char_code_i, .end_of_text_i, .out_valid_o, .out_stall_i, .out_char_o,
    .end_of_line_o, .word_cut_o
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // stall generator and result checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) sb.check_char(out_char_o, end_of_line_o, word_cut_o);
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // valid stays up after a beat until an idle cycle or the end of a burst
  task automatic send_byte(bit [7:0] ch, bit eot);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= ch;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(ch, eot);
  endtask

  task automatic set_width(bit [5:0] w);
    in_valid_i <= 1'b0;
    while (sb.char_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.width_reg = w;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  function automatic bit [7:0] rand_letter();
    bit [7:0] c;
    do c = 8'($urandom_range(255)); while (c == ftj_pkg::SPACE_CODE);
    return c;
  endfunction

  task automatic send_random_text(int n_bytes);
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < 25) send_byte(ftj_pkg::SPACE_CODE, i == n_bytes - 1);
      else send_byte(rand_letter(), i == n_bytes - 1);
    end
  endtask

  initial begin
    bit [5:0] widths[6] = '{6'd1, 6'd0, 6'd63, 6'd7, 6'd12, 6'd32};
    sb = new();
    idle_pct = 34;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = 0;
    in_valid_i = 0;
    char_code_i = 0;
    end_of_text_i = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty text, lone word, gaps, overlong word, extreme bytes
    send_byte(ftj_pkg::SPACE_CODE, 1'b1);
    send_text("ab  cd e fghij");
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(ftj_pkg::SPACE_CODE, 1'b1);
    set_width(6'd5);
    send_text("abcdefgh x yz");
    foreach (widths[k]) begin
      set_width(widths[k]);
      if (k == 3) idle_pct = 0;
      else idle_pct = 34;
      // many short words exercise word capacity at width 32
      if (k == 5) send_text("a b c d e f g h i j k l m n o p q r");
      send_random_text(40);
    end
    in_valid_i <= 1'b0;
    while (sb.char_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.char_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
